// File: hdl/gve_pkg.sv
// shared types and constants of the granular voice engine
// used by granular_voice_engine and gve_div; no dependencies
`timescale 1ns / 1ps

package gve_pkg;

    localparam int DEF_BUFFER_DEPTH = 65536;
    localparam int DEF_VOICES       = 32;
    localparam int DEF_SAMPLE_BITS  = 16;

    // width of the shared divider (dividend and divisor)
    localparam int DIV_W = 26;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [3:0] REG_GRAIN_LENGTH   = 4'd0;
    localparam logic [3:0] REG_RAMP_PERCENT   = 4'd1;
    localparam logic [3:0] REG_GAP_LENGTH     = 4'd2;
    localparam logic [3:0] REG_OFFSET_SAMPLES = 4'd3;
    localparam logic [3:0] REG_RANDOM_FACTOR  = 4'd4;
    localparam logic [3:0] REG_BUFFER_LENGTH  = 4'd5;
    localparam logic [3:0] REG_VOICE_COUNT    = 4'd6;
    localparam logic [3:0] REG_OUTPUT_GAIN    = 4'd7;

    localparam logic [15:0] RST_GRAIN_LENGTH  = 16'd1323;
    localparam logic [6:0]  RST_RAMP_PERCENT  = 7'd50;
    localparam logic [7:0]  RST_RANDOM_FACTOR = 8'd25;
    localparam logic [5:0]  RST_VOICE_COUNT   = 6'd1;
    localparam logic [15:0] RST_OUTPUT_GAIN   = 16'd32768;

    localparam logic [6:0]  MAX_RAMP   = 7'd100;
    localparam logic [7:0]  MAX_RANDOM = 8'd248;
    localparam logic [16:0] ENV_ONE    = 17'd65536;
    localparam logic [DIV_W-1:0] RAMP_DIVISOR = DIV_W'(200);

    localparam logic [31:0] NOISE_SEED = 32'hACE12468;
    localparam logic [31:0] NOISE_TAPS = 32'hA3000000;

    typedef enum logic [1:0] {
        PH_STOPPED,
        PH_FADEIN,
        PH_SUSTAIN,
        PH_FADEOUT
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CMD,
        S_RS_READ,
        S_RS_LOAD,
        S_RS_WAIT,
        S_RS_WB,
        S_TK_READ,
        S_TK_LOAD,
        S_TK_CHECK,
        S_G_LEN0,
        S_G_LEN1,
        S_G_LEN2,
        S_G_ATT0,
        S_G_ATT1,
        S_G_ATT2,
        S_G_STEP,
        S_G_GAP0,
        S_G_GAP1,
        S_G_GAP2,
        S_G_OFS0,
        S_G_OFS1,
        S_G_OFS2,
        S_G_OFS3,
        S_G_OFS4,
        S_G_OFS5,
        S_G_PTR,
        S_G_MOD,
        S_TK_PLAY,
        S_TK_SAMP,
        S_TK_ENV,
        S_TK_WB,
        S_TK_GAIN,
        S_TK_SAT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

// File: hdl/gve_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on gve_pkg for the request and response structs
`timescale 1ns / 1ps

module gve_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gve_pkg::t_div_req i_req,
    output gve_pkg::t_div_rsp o_rsp
);

    localparam int W  = gve_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [W:0]    trial;
    logic          fits;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= W'(trial - {1'b0, r_div});
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// File: hdl/granular_voice_engine.sv
// granular voice engine: command port, config registers and voice sequencer
// depends on gve_pkg and gve_div
`timescale 1ns / 1ps

// Usage: raise i_start with i_command, i_sample_address and i_sample_value while
// o_busy is low; the transfer happens at that clock edge and o_busy stays high
// until the command is done. Every command answers with one result: o_done is
// high for one cycle with o_audio_out and o_audio_valid (valid only for a tick).
// The receiver cannot stall; a result must be taken in its cycle.
// A write, and a tick with zero buffer length, end in the command state.
// A tick runs the active voices one after the other on one multiplier and
// the shared divider; each voice that starts a new grain runs one to three
// divides (attack, step, pointer wrap), and the output gain and saturation
// follow the last voice. A restart runs one divide per active voice.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once and
// belong between commands. Reset restores the register defaults, stops all
// voices and seeds the noise generator; the sample buffer is not cleared.

module granular_voice_engine #(
    parameter int BUFFER_DEPTH = gve_pkg::DEF_BUFFER_DEPTH,
    parameter int VOICES       = gve_pkg::DEF_VOICES,
    parameter int SAMPLE_BITS  = gve_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_command,
    input  logic [15:0]                   i_sample_address,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_busy,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_audio_out,
    output logic                          o_audio_valid
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int BLW = AW + 1;
    localparam int IW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NW  = ($clog2(VOICES + 1) > 6) ? $clog2(VOICES + 1) : 6;
    localparam int ACW = SB + IW + 1;
    localparam int MA  = (ACW > 26) ? ACW : 26;
    localparam int PW  = MA + 18;
    localparam int OFW = 20;
    localparam int PPW = ((AW > OFW) ? AW : OFW) + 2;
    localparam int DW  = gve_pkg::DIV_W;
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

    typedef struct packed {
        gve_pkg::t_phase    phase;
        logic [16:0]        counter;
        logic [AW-1:0]      ptr;
        logic [16:0]        att;
        logic [16:0]        sus;
        logic [16:0]        rel;
        logic [16:0]        gap;
        logic [16:0]        env;
        logic signed [17:0] step;
    } t_voice;

    // config registers
    logic [15:0]        r_grain_length;
    logic [6:0]         r_ramp_percent;
    logic [15:0]        r_gap_length;
    logic signed [15:0] r_offset_samples;
    logic [7:0]         r_random_factor;
    logic [15:0]        r_buffer_length;
    logic [5:0]         r_voice_count;
    logic [15:0]        r_output_gain;

    gve_pkg::t_state r_state, n_state;

    logic [1:0]           r_cmd;
    logic [15:0]          r_addr;
    logic [SB-1:0]        r_value;
    t_voice               r_v, n_v;
    logic [IW-1:0]        r_idx, n_idx;
    logic signed [ACW-1:0] r_acc, n_acc;
    logic [16:0]          r_cnt, n_cnt;
    logic signed [15:0]   r_n, n_n;
    logic [31:0]          r_lfsr, n_lfsr;
    logic signed [OFW-1:0] r_off, n_off;
    logic signed [PW-1:0] r_prod;
    logic                 r_done, n_done;
    logic [SB-1:0]        r_audio, n_audio;
    logic                 r_avalid, n_avalid;

    // memories
    t_voice               vmem [VOICES];
    t_voice               r_vq;
    logic                 r_vvq;
    logic [VOICES-1:0]    r_vvalid;
    logic                 vmem_we;
    logic [SB-1:0]        bmem [BUFFER_DEPTH];
    logic signed [SB-1:0] r_bq;
    logic                 bmem_we;

    // shared units
    logic signed [MA-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [PW-1:0] mul_p;
    gve_pkg::t_div_req    div_req;
    gve_pkg::t_div_rsp    div_rsp;

    // derived values
    logic [15:0]           l_eff;
    logic [7:0]            rnd_eff;
    logic [6:0]            ramp_eff;
    logic [NW-1:0]         n_eff;
    logic [BLW-1:0]        blen;
    logic                  last_voice;
    logic [31:0]           addr_ext;
    logic                  addr_ok;
    t_voice                vq_eff;
    logic [31:0]           lfsr_nx;
    logic signed [PW-1:0]  sh23;
    logic signed [PW-1:0]  len_sum;
    logic signed [PW-1:0]  gap_sum;
    logic signed [PW-1:0]  t23_sum;
    logic signed [PW-1:0]  t23_q;
    logic signed [16:0]    n_ext;
    logic signed [16:0]    n_abs;
    logic [16:0]           att_q;
    logic signed [PPW-1:0] p_sum;
    logic                  p_wrap;
    logic [BLW-1:0]        p_inc;
    logic signed [18:0]    env_sum;
    logic signed [PW-1:0]  y_full;
    logic                  is_fade;
    t_voice                chk_v;
    logic                  chk_grain;

    gve_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign mul_p = mul_a * mul_b;

    always_comb begin
        l_eff    = (r_grain_length == 16'd0) ? 16'd1 : r_grain_length;
        rnd_eff  = (r_random_factor > gve_pkg::MAX_RANDOM) ? gve_pkg::MAX_RANDOM
                                                           : r_random_factor;
        ramp_eff = (r_ramp_percent > gve_pkg::MAX_RAMP) ? gve_pkg::MAX_RAMP : r_ramp_percent;
        if (r_voice_count == 6'd0) begin
            n_eff = NW'(1);
        end else if (NW'(r_voice_count) > NW'(VOICES)) begin
            n_eff = NW'(VOICES);
        end else begin
            n_eff = NW'(r_voice_count);
        end
        blen = (32'(r_buffer_length) > 32'(BUFFER_DEPTH)) ? BLW'(BUFFER_DEPTH)
                                                          : BLW'(r_buffer_length);
        last_voice = NW'(r_idx) == (n_eff - NW'(1));
        addr_ext   = 32'(r_addr);
        addr_ok    = addr_ext < 32'(BUFFER_DEPTH);
        vq_eff     = r_vvq ? r_vq : '0;
        lfsr_nx    = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? gve_pkg::NOISE_TAPS : 32'd0);
        sh23       = r_prod >>> 23;
        len_sum    = $signed(PW'(l_eff)) + sh23;
        gap_sum    = $signed(PW'(r_gap_length)) + sh23;
        // truncation toward zero for the offset terms
        t23_sum    = r_prod + $signed(PW'(r_prod[PW-1] ? 23'h7FFFFF : 23'h0));
        t23_q      = t23_sum >>> 23;
        n_ext      = 17'(r_n);
        n_abs      = n_ext[16] ? -n_ext : n_ext;
        att_q      = div_rsp.quotient[16:0];
        p_sum      = $signed(PPW'(r_v.ptr)) + PPW'(r_off);
        p_wrap     = p_sum >= $signed(PPW'(blen));
        p_inc      = BLW'(r_v.ptr) + BLW'(1);
        env_sum    = $signed({2'b00, r_v.env}) + 19'(r_v.step);
        y_full     = r_prod >>> 15;
        is_fade    = (r_v.phase == gve_pkg::PH_FADEIN) || (r_v.phase == gve_pkg::PH_FADEOUT);
    end

    // grain phase change when a voice's counter has run out
    always_comb begin
        logic to_sus;
        logic to_gap;
        chk_v     = r_v;
        chk_grain = 1'b0;
        to_sus    = 1'b0;
        to_gap    = 1'b0;
        if (r_v.counter == 17'd0) begin
            if (r_v.phase == gve_pkg::PH_STOPPED) begin
                chk_grain = 1'b1;
            end else begin
                if (r_v.phase == gve_pkg::PH_FADEIN) begin
                    if (r_v.sus != 17'd0) begin
                        chk_v.counter = r_v.sus;
                        chk_v.phase   = gve_pkg::PH_SUSTAIN;
                    end else begin
                        to_sus = 1'b1;
                    end
                end
                if (r_v.phase == gve_pkg::PH_SUSTAIN || to_sus) begin
                    if (r_v.rel != 17'd0) begin
                        chk_v.counter = r_v.rel;
                        chk_v.step    = -r_v.step;
                        chk_v.phase   = gve_pkg::PH_FADEOUT;
                    end else begin
                        to_gap = 1'b1;
                    end
                end
                if (r_v.phase == gve_pkg::PH_FADEOUT || to_gap) begin
                    if (r_v.gap != 17'd0) begin
                        chk_v.counter = r_v.gap;
                        chk_v.phase   = gve_pkg::PH_STOPPED;
                    end else begin
                        chk_grain = 1'b1;
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gve_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = gve_pkg::S_CMD;
                end
            end
            gve_pkg::S_CMD: begin
                case (r_cmd)
                    gve_pkg::CMD_TICK: begin
                        n_state = (blen == '0) ? gve_pkg::S_IDLE : gve_pkg::S_TK_READ;
                    end
                    gve_pkg::CMD_RESTART: n_state = gve_pkg::S_RS_READ;
                    default:              n_state = gve_pkg::S_IDLE;
                endcase
            end
            gve_pkg::S_RS_READ: n_state = gve_pkg::S_RS_LOAD;
            gve_pkg::S_RS_LOAD: n_state = gve_pkg::S_RS_WAIT;
            gve_pkg::S_RS_WAIT: begin
                if (!div_rsp.busy) begin
                    n_state = gve_pkg::S_RS_WB;
                end
            end
            gve_pkg::S_RS_WB: n_state = last_voice ? gve_pkg::S_IDLE : gve_pkg::S_RS_READ;
            gve_pkg::S_TK_READ: n_state = gve_pkg::S_TK_LOAD;
            gve_pkg::S_TK_LOAD: n_state = gve_pkg::S_TK_CHECK;
            gve_pkg::S_TK_CHECK: n_state = chk_grain ? gve_pkg::S_G_LEN0 : gve_pkg::S_TK_PLAY;
            gve_pkg::S_G_LEN0: n_state = gve_pkg::S_G_LEN1;
            gve_pkg::S_G_LEN1: n_state = gve_pkg::S_G_LEN2;
            gve_pkg::S_G_LEN2: n_state = gve_pkg::S_G_ATT0;
            gve_pkg::S_G_ATT0: n_state = gve_pkg::S_G_ATT1;
            gve_pkg::S_G_ATT1: n_state = gve_pkg::S_G_ATT2;
            gve_pkg::S_G_ATT2: begin
                if (!div_rsp.busy) begin
                    n_state = (att_q != 17'd0) ? gve_pkg::S_G_STEP : gve_pkg::S_G_GAP0;
                end
            end
            gve_pkg::S_G_STEP: begin
                if (!div_rsp.busy) begin
                    n_state = gve_pkg::S_G_GAP0;
                end
            end
            gve_pkg::S_G_GAP0: n_state = gve_pkg::S_G_GAP1;
            gve_pkg::S_G_GAP1: n_state = gve_pkg::S_G_GAP2;
            gve_pkg::S_G_GAP2: n_state = gve_pkg::S_G_OFS0;
            gve_pkg::S_G_OFS0: n_state = gve_pkg::S_G_OFS1;
            gve_pkg::S_G_OFS1: n_state = gve_pkg::S_G_OFS2;
            gve_pkg::S_G_OFS2: n_state = gve_pkg::S_G_OFS3;
            gve_pkg::S_G_OFS3: n_state = gve_pkg::S_G_OFS4;
            gve_pkg::S_G_OFS4: n_state = gve_pkg::S_G_OFS5;
            gve_pkg::S_G_OFS5: n_state = gve_pkg::S_G_PTR;
            gve_pkg::S_G_PTR: n_state = p_wrap ? gve_pkg::S_G_MOD : gve_pkg::S_TK_PLAY;
            gve_pkg::S_G_MOD: begin
                if (!div_rsp.busy) begin
                    n_state = gve_pkg::S_TK_PLAY;
                end
            end
            gve_pkg::S_TK_PLAY: n_state = gve_pkg::S_TK_SAMP;
            gve_pkg::S_TK_SAMP: begin
                if (r_v.phase != gve_pkg::PH_STOPPED && is_fade) begin
                    n_state = gve_pkg::S_TK_ENV;
                end else begin
                    n_state = gve_pkg::S_TK_WB;
                end
            end
            gve_pkg::S_TK_ENV: n_state = gve_pkg::S_TK_WB;
            gve_pkg::S_TK_WB: n_state = last_voice ? gve_pkg::S_TK_GAIN : gve_pkg::S_TK_READ;
            gve_pkg::S_TK_GAIN: n_state = gve_pkg::S_TK_SAT;
            gve_pkg::S_TK_SAT: n_state = gve_pkg::S_IDLE;
            default: n_state = gve_pkg::S_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb begin
        n_v      = r_v;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_lfsr   = r_lfsr;
        n_off    = r_off;
        n_done   = 1'b0;
        n_audio  = '0;
        n_avalid = 1'b0;
        vmem_we  = 1'b0;
        bmem_we  = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;
        case (r_state)
            gve_pkg::S_CMD: begin
                n_idx = '0;
                n_acc = '0;
                case (r_cmd)
                    gve_pkg::CMD_WRITE: begin
                        bmem_we = addr_ok;
                        n_done  = 1'b1;
                    end
                    gve_pkg::CMD_TICK: begin
                        if (blen == '0) begin
                            n_done   = 1'b1;
                            n_avalid = 1'b1;
                        end
                    end
                    gve_pkg::CMD_RESTART: begin
                    end
                    default: n_done = 1'b1;
                endcase
            end
            gve_pkg::S_RS_READ: begin
                mul_a = MA'(r_idx);
                mul_b = 18'(l_eff);
            end
            gve_pkg::S_RS_LOAD: begin
                n_v              = vq_eff;
                div_req.start    = 1'b1;
                div_req.dividend = DW'(r_prod[23:0]);
                div_req.divisor  = DW'(n_eff);
            end
            gve_pkg::S_RS_WAIT: begin
                if (!div_rsp.busy) begin
                    n_v.counter = div_rsp.quotient[16:0];
                    n_v.ptr     = '0;
                    n_v.phase   = gve_pkg::PH_STOPPED;
                end
            end
            gve_pkg::S_RS_WB: begin
                vmem_we = 1'b1;
                n_idx   = r_idx + IW'(1);
                if (last_voice) begin
                    n_done = 1'b1;
                end
            end
            gve_pkg::S_TK_LOAD: n_v = vq_eff;
            gve_pkg::S_TK_CHECK: begin
                if (!chk_grain) begin
                    n_v = chk_v;
                end
            end
            gve_pkg::S_G_LEN0, gve_pkg::S_G_OFS3: begin
                n_lfsr = lfsr_nx;
                n_n    = lfsr_nx[31:16];
                mul_a  = MA'(l_eff);
                mul_b  = 18'(rnd_eff);
                if (r_state == gve_pkg::S_G_OFS3) begin
                    n_off = OFW'(t23_q);
                end
            end
            gve_pkg::S_G_LEN1, gve_pkg::S_G_GAP1, gve_pkg::S_G_OFS4: begin
                mul_a = r_prod[MA-1:0];
                mul_b = 18'(r_n);
            end
            gve_pkg::S_G_LEN2: begin
                n_cnt = len_sum[PW-1] ? 17'd0 : len_sum[16:0];
            end
            gve_pkg::S_G_ATT0: begin
                mul_a = MA'(r_cnt);
                mul_b = 18'(ramp_eff);
            end
            gve_pkg::S_G_ATT1: begin
                div_req.start    = 1'b1;
                div_req.dividend = DW'(r_prod[23:0]);
                div_req.divisor  = gve_pkg::RAMP_DIVISOR;
            end
            gve_pkg::S_G_ATT2: begin
                if (!div_rsp.busy) begin
                    n_v.att = att_q;
                    n_v.rel = att_q;
                    n_v.sus = r_cnt - 17'(att_q << 1);
                    n_v.env = '0;
                    if (att_q != 17'd0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DW'(gve_pkg::ENV_ONE);
                        div_req.divisor  = DW'(att_q);
                    end else begin
                        n_v.step    = '0;
                        n_v.counter = r_cnt - 17'(att_q << 1);
                        n_v.phase   = gve_pkg::PH_SUSTAIN;
                    end
                end
            end
            gve_pkg::S_G_STEP: begin
                if (!div_rsp.busy) begin
                    n_v.step    = $signed(div_rsp.quotient[17:0]);
                    n_v.counter = r_v.att;
                    n_v.phase   = gve_pkg::PH_FADEIN;
                end
            end
            gve_pkg::S_G_GAP0: begin
                n_lfsr = lfsr_nx;
                n_n    = lfsr_nx[31:16];
                mul_a  = MA'(r_gap_length);
                mul_b  = 18'(rnd_eff);
            end
            gve_pkg::S_G_GAP2: begin
                n_v.gap = gap_sum[PW-1] ? 17'd0 : gap_sum[16:0];
            end
            gve_pkg::S_G_OFS0: begin
                n_lfsr = lfsr_nx;
                n_n    = lfsr_nx[31:16];
            end
            gve_pkg::S_G_OFS1: begin
                mul_a = MA'($unsigned(n_abs));
                mul_b = 18'(rnd_eff);
            end
            gve_pkg::S_G_OFS2: begin
                // scale factor one plus r times |n| in Q23
                mul_a = MA'({1'b1, r_prod[22:0]});
                mul_b = 18'(r_offset_samples);
            end
            gve_pkg::S_G_OFS5: begin
                n_off = r_off + OFW'(t23_q);
            end
            gve_pkg::S_G_PTR: begin
                if (p_wrap) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(p_sum);
                    div_req.divisor  = DW'(blen);
                end else if (p_sum[PPW-1]) begin
                    n_v.ptr = '0;
                end else begin
                    n_v.ptr = p_sum[AW-1:0];
                end
            end
            gve_pkg::S_G_MOD: begin
                if (!div_rsp.busy) begin
                    n_v.ptr = div_rsp.remainder[AW-1:0];
                end
            end
            gve_pkg::S_TK_PLAY: begin
                if (r_v.phase != gve_pkg::PH_STOPPED) begin
                    n_v.ptr = (p_inc >= blen) ? '0 : p_inc[AW-1:0];
                end
                if (r_v.counter != 17'd0) begin
                    n_v.counter = r_v.counter - 17'd1;
                end
            end
            gve_pkg::S_TK_SAMP: begin
                if (r_v.phase != gve_pkg::PH_STOPPED) begin
                    if (is_fade) begin
                        mul_a = MA'(r_bq);
                        mul_b = 18'(r_v.env);
                        if (env_sum < 19'sd0) begin
                            n_v.env = '0;
                        end else if (env_sum > $signed({2'b00, gve_pkg::ENV_ONE})) begin
                            n_v.env = gve_pkg::ENV_ONE;
                        end else begin
                            n_v.env = env_sum[16:0];
                        end
                    end else begin
                        n_acc = r_acc + ACW'(r_bq);
                    end
                end
            end
            gve_pkg::S_TK_ENV: begin
                n_acc = r_acc + ACW'(r_prod >>> 16);
            end
            gve_pkg::S_TK_WB: begin
                vmem_we = 1'b1;
                n_idx   = r_idx + IW'(1);
            end
            gve_pkg::S_TK_GAIN: begin
                mul_a = MA'(r_acc);
                mul_b = 18'(r_output_gain);
            end
            gve_pkg::S_TK_SAT: begin
                n_done   = 1'b1;
                n_avalid = 1'b1;
                if (y_full > SAT_HI) begin
                    n_audio = SAT_HI[SB-1:0];
                end else if (y_full < SAT_LO) begin
                    n_audio = SAT_LO[SB-1:0];
                end else begin
                    n_audio = y_full[SB-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grain_length   <= gve_pkg::RST_GRAIN_LENGTH;
            r_ramp_percent   <= gve_pkg::RST_RAMP_PERCENT;
            r_gap_length     <= '0;
            r_offset_samples <= '0;
            r_random_factor  <= gve_pkg::RST_RANDOM_FACTOR;
            r_buffer_length  <= '0;
            r_voice_count    <= gve_pkg::RST_VOICE_COUNT;
            r_output_gain    <= gve_pkg::RST_OUTPUT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gve_pkg::REG_GRAIN_LENGTH:   r_grain_length   <= i_cfg_data;
                gve_pkg::REG_RAMP_PERCENT:   r_ramp_percent   <= i_cfg_data[6:0];
                gve_pkg::REG_GAP_LENGTH:     r_gap_length     <= i_cfg_data;
                gve_pkg::REG_OFFSET_SAMPLES: r_offset_samples <= $signed(i_cfg_data);
                gve_pkg::REG_RANDOM_FACTOR:  r_random_factor  <= i_cfg_data[7:0];
                gve_pkg::REG_BUFFER_LENGTH:  r_buffer_length  <= i_cfg_data;
                gve_pkg::REG_VOICE_COUNT:    r_voice_count    <= i_cfg_data[5:0];
                gve_pkg::REG_OUTPUT_GAIN:    r_output_gain    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gve_pkg::S_IDLE;
            r_lfsr   <= gve_pkg::NOISE_SEED;
            r_done   <= 1'b0;
            r_avalid <= 1'b0;
            r_audio  <= '0;
            r_idx    <= '0;
            r_vvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_lfsr   <= n_lfsr;
            r_done   <= n_done;
            r_avalid <= n_avalid;
            r_audio  <= n_audio;
            r_idx    <= n_idx;
            if (vmem_we) begin
                r_vvalid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gve_pkg::S_IDLE && i_start) begin
            r_cmd   <= i_command;
            r_addr  <= i_sample_address;
            r_value <= i_sample_value;
        end
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_n    <= n_n;
        r_off  <= n_off;
        r_prod <= mul_p;
    end

    // voice state memory, entries without a valid bit read as stopped and zero
    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            vmem[r_idx] <= r_v;
        end
        r_vq  <= vmem[r_idx];
        r_vvq <= r_vvalid[r_idx];
    end

    // source sample buffer
    always_ff @(posedge i_clk) begin
        if (bmem_we) begin
            bmem[addr_ext[AW-1:0]] <= r_value;
        end
        r_bq <= $signed(bmem[r_v.ptr]);
    end

    assign o_busy        = r_state != gve_pkg::S_IDLE;
    assign o_done        = r_done;
    assign o_audio_out   = $signed(r_audio);
    assign o_audio_valid = r_avalid;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command transfer did not start the sequencer");

    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_audio_valid || o_audio_out != '0) |-> o_done)
        else $error("result fields set outside a result cycle");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule
